### hdl/slpg_pkg.sv
// Shared types, codes and the color wheel for the status LED pattern generator.
`default_nettype none

package slpg_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int PERIOD_W        = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_HALF    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_HALF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAINBOW_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STROBE_ON    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STROBE_OFF   = 3'd5;

    localparam logic [7:0]          BRIGHTNESS_RST   = 8'd255;
    localparam logic [PERIOD_W-1:0] SLOW_HALF_RST    = 16'd300;
    localparam logic [PERIOD_W-1:0] FAST_HALF_RST    = 16'd150;
    localparam logic [PERIOD_W-1:0] RAINBOW_STEP_RST = 16'd15;
    localparam logic [PERIOD_W-1:0] STROBE_ON_RST    = 16'd150;
    localparam logic [PERIOD_W-1:0] STROBE_OFF_RST   = 16'd150;

    localparam logic REQ_TICK     = 1'b0;
    localparam logic REQ_SET_MODE = 1'b1;

    localparam logic [3:0] MODE_OFF        = 4'd0;
    localparam logic [3:0] MODE_STEADY_A   = 4'd1;
    localparam logic [3:0] MODE_STEADY_C   = 4'd3;
    localparam logic [3:0] MODE_GREEN_BL_A = 4'd4;
    localparam logic [3:0] MODE_RED_BL_A   = 4'd5;
    localparam logic [3:0] MODE_GREEN_BL_B = 4'd6;
    localparam logic [3:0] MODE_CYAN_BL    = 4'd7;
    localparam logic [3:0] MODE_RAINBOW    = 4'd8;
    localparam logic [3:0] MODE_STROBE     = 4'd9;
    localparam logic [3:0] MODE_RED_BL_B   = 4'd10;

    localparam logic [7:0] PHASE_GREEN = 8'd0;
    localparam logic [7:0] PHASE_ON    = 8'd1;
    localparam logic [7:0] PHASE_DARK  = 8'd2;

    localparam logic [7:0] WHEEL_SEG1 = 8'd85;
    localparam logic [7:0] WHEEL_SEG2 = 8'd170;
    localparam logic [7:0] FULL       = 8'd255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic                emit;
        rgb_t                color;
    } result_t;

    typedef struct packed {
        logic [7:0]          brightness;
        logic [PERIOD_W-1:0] slow_half;
        logic [PERIOD_W-1:0] fast_half;
        logic [PERIOD_W-1:0] rainbow_step;
        logic [PERIOD_W-1:0] strobe_on;
        logic [PERIOD_W-1:0] strobe_off;
    } cfg_t;

    localparam rgb_t COLOR_BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};
    localparam rgb_t COLOR_GREEN = '{red: 8'd0, green: FULL, blue: 8'd0};
    localparam rgb_t COLOR_RED   = '{red: FULL, green: 8'd0, blue: 8'd0};
    localparam rgb_t COLOR_CYAN  = '{red: 8'd0, green: FULL, blue: FULL};

    // Three linear ramps around the hue circle.
    function automatic rgb_t wheel(input logic [7:0] pos);
        logic [7:0] q;
        logic [9:0] m;
        logic [7:0] up;
        rgb_t       c;
        if (pos < WHEEL_SEG1)
        begin
            q = pos;
        end
        else if (pos < WHEEL_SEG2)
        begin
            q = pos - WHEEL_SEG1;
        end
        else
        begin
            q = pos - WHEEL_SEG2;
        end
        m  = 10'(q) * 10'd3;
        up = m[7:0];
        if (pos < WHEEL_SEG1)
        begin
            c = '{red: up, green: FULL - up, blue: 8'd0};
        end
        else if (pos < WHEEL_SEG2)
        begin
            c = '{red: FULL - up, green: 8'd0, blue: up};
        end
        else
        begin
            c = '{red: 8'd0, green: up, blue: FULL - up};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/slpg_cfg.sv
// Configuration register file for the status LED pattern generator.
`default_nettype none

module slpg_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [slpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [slpg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output slpg_pkg::cfg_t                          cfg
);

    slpg_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness   <= slpg_pkg::BRIGHTNESS_RST;
            cfg_reg.slow_half    <= slpg_pkg::SLOW_HALF_RST;
            cfg_reg.fast_half    <= slpg_pkg::FAST_HALF_RST;
            cfg_reg.rainbow_step <= slpg_pkg::RAINBOW_STEP_RST;
            cfg_reg.strobe_on    <= slpg_pkg::STROBE_ON_RST;
            cfg_reg.strobe_off   <= slpg_pkg::STROBE_OFF_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                slpg_pkg::CFG_BRIGHTNESS:   cfg_reg.brightness   <= cfg_data[7:0];
                slpg_pkg::CFG_SLOW_HALF:    cfg_reg.slow_half    <= cfg_data;
                slpg_pkg::CFG_FAST_HALF:    cfg_reg.fast_half    <= cfg_data;
                slpg_pkg::CFG_RAINBOW_STEP: cfg_reg.rainbow_step <= cfg_data;
                slpg_pkg::CFG_STROBE_ON:    cfg_reg.strobe_on    <= cfg_data;
                slpg_pkg::CFG_STROBE_OFF:   cfg_reg.strobe_off   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hdl/slpg_core.sv
// Mode, timer and animation state with the per-request update logic.
`default_nettype none

module slpg_core #(
    parameter int TIMER_WIDTH = slpg_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic       req_type,
    input  wire logic [3:0] new_mode,
    input  wire slpg_pkg::cfg_t cfg,
    output slpg_pkg::result_t result
);

    localparam int CMP_W = (TIMER_WIDTH > slpg_pkg::PERIOD_W) ? TIMER_WIDTH
                                                                : slpg_pkg::PERIOD_W;

    logic [3:0]             mode_reg,    mode_next;
    logic [TIMER_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [7:0]             phase_reg,   phase_next;
    logic                   lit_reg,     lit_next;

    logic [TIMER_WIDTH-1:0] elapsed_inc;
    logic [CMP_W-1:0]       elapsed_cmp;
    logic [CMP_W-1:0]       half_cmp;
    logic                   half_hit;
    logic                   step_hit;
    logic                   on_hit;
    logic                   off_hit;
    logic [7:0]             phase_inc;
    slpg_pkg::rgb_t         lit_color;
    slpg_pkg::result_t      res;

    assign elapsed_inc = (elapsed_reg != {TIMER_WIDTH{1'b1}}) ?
                         elapsed_reg + TIMER_WIDTH'(1) : elapsed_reg;
    assign elapsed_cmp = CMP_W'(elapsed_inc);
    assign half_cmp    = (mode_reg == slpg_pkg::MODE_CYAN_BL) ? CMP_W'(cfg.fast_half)
                                                               : CMP_W'(cfg.slow_half);
    assign half_hit    = elapsed_cmp >= half_cmp;
    assign step_hit    = elapsed_cmp >= CMP_W'(cfg.rainbow_step);
    assign on_hit      = elapsed_cmp >= CMP_W'(cfg.strobe_on);
    assign off_hit     = elapsed_cmp >= CMP_W'(cfg.strobe_off);
    assign phase_inc   = phase_reg + 8'd1;

    always_comb
    begin
        case (mode_reg)
            slpg_pkg::MODE_RED_BL_A,
            slpg_pkg::MODE_RED_BL_B: lit_color = slpg_pkg::COLOR_RED;
            slpg_pkg::MODE_CYAN_BL:  lit_color = slpg_pkg::COLOR_CYAN;
            default:                 lit_color = slpg_pkg::COLOR_GREEN;
        endcase
    end

    always_comb
    begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        lit_next     = lit_reg;
        res.emit     = 1'b0;
        res.color    = slpg_pkg::COLOR_BLACK;
        if (fire)
        begin
            if (req_type == slpg_pkg::REQ_SET_MODE)
            begin
                if (new_mode != mode_reg)
                begin
                    mode_next    = new_mode;
                    elapsed_next = '0;
                    phase_next   = '0;
                    lit_next     = 1'b0;
                    if (new_mode == slpg_pkg::MODE_OFF)
                    begin
                        res.emit = 1'b1;
                    end
                    else if (new_mode >= slpg_pkg::MODE_STEADY_A &&
                             new_mode <= slpg_pkg::MODE_STEADY_C)
                    begin
                        res.emit  = 1'b1;
                        res.color = slpg_pkg::COLOR_GREEN;
                    end
                end
            end
            else
            begin
                elapsed_next = elapsed_inc;
                case (mode_reg)
                    slpg_pkg::MODE_GREEN_BL_A,
                    slpg_pkg::MODE_GREEN_BL_B,
                    slpg_pkg::MODE_RED_BL_A,
                    slpg_pkg::MODE_RED_BL_B,
                    slpg_pkg::MODE_CYAN_BL:
                    begin
                        if (half_hit)
                        begin
                            elapsed_next = '0;
                            lit_next     = !lit_reg;
                            res.emit     = 1'b1;
                            res.color    = lit_reg ? slpg_pkg::COLOR_BLACK : lit_color;
                        end
                    end
                    slpg_pkg::MODE_RAINBOW:
                    begin
                        if (step_hit)
                        begin
                            elapsed_next = '0;
                            phase_next   = phase_inc;
                            res.emit     = 1'b1;
                            res.color    = slpg_pkg::wheel(phase_inc);
                        end
                    end
                    slpg_pkg::MODE_STROBE:
                    begin
                        if (phase_reg == slpg_pkg::PHASE_GREEN)
                        begin
                            phase_next   = slpg_pkg::PHASE_ON;
                            elapsed_next = '0;
                            res.emit     = 1'b1;
                            res.color    = slpg_pkg::COLOR_GREEN;
                        end
                        else if (phase_reg == slpg_pkg::PHASE_ON)
                        begin
                            if (on_hit)
                            begin
                                phase_next   = slpg_pkg::PHASE_DARK;
                                elapsed_next = '0;
                                res.emit     = 1'b1;
                            end
                        end
                        else if (off_hit)
                        begin
                            phase_next   = slpg_pkg::PHASE_GREEN;
                            elapsed_next = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= slpg_pkg::MODE_OFF;
            elapsed_reg <= '0;
            phase_reg   <= '0;
            lit_reg     <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            phase_reg   <= phase_next;
            lit_reg     <= lit_next;
        end
    end

    assign result = res;

endmodule

`default_nettype wire

### hdl/status_led_pattern_generator.sv
// Top level of the status LED pattern generator: request and result registers.
//
//  Channel   Direction  Handshake              Payload
//  request   in         in_valid / in_ready    req_type, new_mode
//  result    out        out_valid / out_ready  red, green, blue, level
//  config    in         cfg_wr_en              cfg_index, cfg_data
//
// One request is taken every cycle while results are being drained.
// An accepted request waits in the request register, which feeds the mode and
// timer logic, and the result register captures its result.
// A held result stalls the request register, which then drops in_ready when full.
// Reset loads valid, core and config registers at once, payloads excepted; no sweep.
`default_nettype none

module status_led_pattern_generator #(
    parameter int TIMER_WIDTH = slpg_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output wire logic                             in_ready,
    input  wire logic                             req_type,
    input  wire logic [3:0]                       new_mode,
    output wire logic                             out_valid,
    input  wire logic                             out_ready,
    output wire logic [7:0]                       red,
    output wire logic [7:0]                       green,
    output wire logic [7:0]                       blue,
    output wire logic [7:0]                       level,
    input  wire logic                             cfg_wr_en,
    input  wire logic [slpg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [slpg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    slpg_pkg::cfg_t    cfg;
    slpg_pkg::result_t result;

    logic           req_vld_reg;
    logic           req_type_reg;
    logic [3:0]     req_mode_reg;
    logic           out_vld_reg;
    slpg_pkg::rgb_t color_reg;
    logic [7:0]     level_reg;
    logic           advance;
    logic           fire;

    assign advance  = !out_vld_reg || out_ready;
    assign fire     = req_vld_reg && advance;
    assign in_ready = !req_vld_reg || advance;

    slpg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slpg_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .req_type (req_type_reg),
        .new_mode (req_mode_reg),
        .cfg      (cfg),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                req_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= fire && result.emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_type_reg <= req_type;
            req_mode_reg <= new_mode;
        end
        if (fire && result.emit)
        begin
            color_reg <= result.color;
            level_reg <= cfg.brightness;
        end
    end

    assign out_valid = out_vld_reg;
    assign red       = color_reg.red;
    assign green     = color_reg.green;
    assign blue      = color_reg.blue;
    assign level     = level_reg;

endmodule

`default_nettype wire

### hdl/slpg_checker.sv
// Port-level checker for the status LED pattern generator and its bind.
`default_nettype none

module slpg_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue,
    input wire logic [7:0] level
);

    logic [9:0] color_sum;

    assign color_sum = 10'(red) + 10'(green) + 10'(blue);

    // A stalled result must stay up.
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result must keep its color and level.
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(red) && $stable(green) &&
                                    $stable(blue) && $stable(level))
        else $error("result payload changed while stalled");

    // Every color is black, a single full channel, cyan or a wheel hue.
    a_color_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (color_sum == 10'd0 || color_sum == 10'd255 ||
                       color_sum == 10'd510))
        else $error("result color outside the pattern set");

    // A fresh result must trace back to an accepted request through both registers.
    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching request");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .level     (level)
);

`default_nettype wire

### dv/slpg_checker.sv
// Checker for the status LED pattern generator: predicts each color and compares results.
`timescale 1ns / 1ps

module slpg_scoreboard #(
    parameter int TIMER_WIDTH = slpg_pkg::TIMER_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             req_type,
    input  logic [3:0]                       new_mode,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [7:0]                       red,
    input  logic [7:0]                       green,
    input  logic [7:0]                       blue,
    input  logic [7:0]                       level,
    input  logic                             cfg_wr_en,
    input  logic [slpg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [slpg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               errors,
    output int                               pending
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] level;
    } led_color_t;

    led_color_t pending_colors[$];

    logic [7:0]             brightness_q;
    logic [15:0]            slow_half_q;
    logic [15:0]            fast_half_q;
    logic [15:0]            step_period_q;
    logic [15:0]            strobe_on_q;
    logic [15:0]            strobe_off_q;

    logic [3:0]             mode_q;
    logic [TIMER_WIDTH-1:0] elapsed_q;
    logic [7:0]             phase_q;
    logic                   lit_q;

    int                     fail_count;
    bit                     color_written;
    led_color_t             next_color;
    led_color_t             seen_color;

    function automatic led_color_t paint(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
        return '{red: r, green: g, blue: b, level: brightness_q};
    endfunction

    function automatic led_color_t wheel_color(input logic [7:0] pos);
        logic [7:0] ramp;
        if (pos < slpg_pkg::WHEEL_SEG1)
        begin
            ramp = 8'(3 * pos);
            return paint(ramp, slpg_pkg::FULL - ramp, 8'd0);
        end
        else if (pos < slpg_pkg::WHEEL_SEG2)
        begin
            ramp = 8'(3 * (pos - slpg_pkg::WHEEL_SEG1));
            return paint(slpg_pkg::FULL - ramp, 8'd0, ramp);
        end
        else
        begin
            ramp = 8'(3 * (pos - slpg_pkg::WHEEL_SEG2));
            return paint(8'd0, ramp, slpg_pkg::FULL - ramp);
        end
    endfunction

    task automatic toggle_blink(input logic [15:0] half, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b,
                                output bit written, output led_color_t c);
        written = 1'b0;
        c       = '0;
        if (elapsed_q >= half)
        begin
            elapsed_q = '0;
            lit_q     = !lit_q;
            written   = 1'b1;
            c         = lit_q ? paint(r, g, b) : paint(8'd0, 8'd0, 8'd0);
        end
    endtask

    task automatic advance_pattern(input logic req, input logic [3:0] m,
                                   output bit written, output led_color_t c);
        written = 1'b0;
        c       = '0;
        if (req == slpg_pkg::REQ_SET_MODE)
        begin
            if (m != mode_q)
            begin
                mode_q    = m;
                elapsed_q = '0;
                phase_q   = '0;
                lit_q     = 1'b0;
                if (m == slpg_pkg::MODE_OFF)
                begin
                    written = 1'b1;
                    c       = paint(8'd0, 8'd0, 8'd0);
                end
                else if (m >= slpg_pkg::MODE_STEADY_A && m <= slpg_pkg::MODE_STEADY_C)
                begin
                    written = 1'b1;
                    c       = paint(8'd0, slpg_pkg::FULL, 8'd0);
                end
            end
        end
        else
        begin
            if (elapsed_q != {TIMER_WIDTH{1'b1}})
            begin
                elapsed_q = elapsed_q + 1'b1;
            end
            case (mode_q)
                slpg_pkg::MODE_GREEN_BL_A, slpg_pkg::MODE_GREEN_BL_B:
                begin
                    toggle_blink(slow_half_q, 8'd0, slpg_pkg::FULL, 8'd0, written, c);
                end
                slpg_pkg::MODE_RED_BL_A, slpg_pkg::MODE_RED_BL_B:
                begin
                    toggle_blink(slow_half_q, slpg_pkg::FULL, 8'd0, 8'd0, written, c);
                end
                slpg_pkg::MODE_CYAN_BL:
                begin
                    toggle_blink(fast_half_q, 8'd0, slpg_pkg::FULL, slpg_pkg::FULL,
                                 written, c);
                end
                slpg_pkg::MODE_RAINBOW:
                begin
                    if (elapsed_q >= step_period_q)
                    begin
                        elapsed_q = '0;
                        phase_q   = phase_q + 8'd1;
                        written   = 1'b1;
                        c         = wheel_color(phase_q);
                    end
                end
                slpg_pkg::MODE_STROBE:
                begin
                    if (phase_q == slpg_pkg::PHASE_GREEN)
                    begin
                        phase_q   = slpg_pkg::PHASE_ON;
                        elapsed_q = '0;
                        written   = 1'b1;
                        c         = paint(8'd0, slpg_pkg::FULL, 8'd0);
                    end
                    else if (phase_q == slpg_pkg::PHASE_ON)
                    begin
                        if (elapsed_q >= strobe_on_q)
                        begin
                            phase_q   = slpg_pkg::PHASE_DARK;
                            elapsed_q = '0;
                            written   = 1'b1;
                            c         = paint(8'd0, 8'd0, 8'd0);
                        end
                    end
                    else if (elapsed_q >= strobe_off_q)
                    begin
                        phase_q   = slpg_pkg::PHASE_GREEN;
                        elapsed_q = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_q  = slpg_pkg::BRIGHTNESS_RST;
            slow_half_q   = slpg_pkg::SLOW_HALF_RST;
            fast_half_q   = slpg_pkg::FAST_HALF_RST;
            step_period_q = slpg_pkg::RAINBOW_STEP_RST;
            strobe_on_q   = slpg_pkg::STROBE_ON_RST;
            strobe_off_q  = slpg_pkg::STROBE_OFF_RST;
            mode_q        = slpg_pkg::MODE_OFF;
            elapsed_q     = '0;
            phase_q       = '0;
            lit_q         = 1'b0;
            fail_count    = 0;
            pending_colors.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_color = '{red: red, green: green, blue: blue, level: level};
                if (pending_colors.size() == 0)
                begin
                    $error("unexpected color: red %0d green %0d blue %0d level %0d",
                           red, green, blue, level);
                    fail_count++;
                end
                else
                begin
                    next_color = pending_colors.pop_front();
                    check_field("red", next_color.red, seen_color.red);
                    check_field("green", next_color.green, seen_color.green);
                    check_field("blue", next_color.blue, seen_color.blue);
                    check_field("level", next_color.level, seen_color.level);
                end
            end
            if (in_valid && in_ready)
            begin
                advance_pattern(req_type, new_mode, color_written, next_color);
                if (color_written)
                begin
                    pending_colors.push_back(next_color);
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    slpg_pkg::CFG_BRIGHTNESS:   brightness_q  = cfg_data[7:0];
                    slpg_pkg::CFG_SLOW_HALF:    slow_half_q   = cfg_data;
                    slpg_pkg::CFG_FAST_HALF:    fast_half_q   = cfg_data;
                    slpg_pkg::CFG_RAINBOW_STEP: step_period_q = cfg_data;
                    slpg_pkg::CFG_STROBE_ON:    strobe_on_q   = cfg_data;
                    slpg_pkg::CFG_STROBE_OFF:   strobe_off_q  = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            errors  <= fail_count;
            pending <= pending_colors.size();
        end
    end

endmodule

### dv/tb_status_led_pattern_generator.sv
// Testbench top for the status LED pattern generator: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module tb_status_led_pattern_generator;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic                            req_type  = slpg_pkg::REQ_TICK;
    logic [3:0]                      new_mode  = slpg_pkg::MODE_OFF;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [7:0]                      red;
    logic [7:0]                      green;
    logic [7:0]                      blue;
    logic [7:0]                      level;
    logic                            cfg_wr_en = 1'b0;
    logic [slpg_pkg::CFG_IDX_W-1:0]  cfg_index = slpg_pkg::CFG_BRIGHTNESS;
    logic [slpg_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int errors;
    int pending;
    bit tx_gaps        = 1'b1;
    bit rx_stalls      = 1'b1;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    status_led_pattern_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .new_mode  (new_mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .level     (level),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    slpg_scoreboard u_scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .new_mode  (new_mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .level     (level),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // The receiver takes one color per loop after a random stall when stalls are on, or one long hold on request.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_stalls ? $urandom_range(0, 16) : 0;
            if (long_hold_req && !long_hold_done)
            begin
                stall          = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_request(input logic req, input logic [3:0] mode);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        new_mode <= mode;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 88)
        begin
            send_request(slpg_pkg::REQ_TICK, 4'($urandom));
        end
        else if (pick < 96)
        begin
            send_request(slpg_pkg::REQ_SET_MODE,
                         4'($urandom_range(slpg_pkg::MODE_GREEN_BL_A,
                                           slpg_pkg::MODE_RED_BL_B)));
        end
        else
        begin
            send_request(slpg_pkg::REQ_SET_MODE, 4'($urandom));
        end
    endtask

    task automatic wait_all_colors();
        in_valid <= 1'b0;
        do
        begin
            while (pending != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
        while (pending != 0);
    endtask

    task automatic write_reg(input logic [slpg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slpg_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] bright, input logic [15:0] slow,
                                input logic [15:0] fast, input logic [15:0] step,
                                input logic [15:0] on_time, input logic [15:0] off_time);
        write_reg(slpg_pkg::CFG_BRIGHTNESS, bright);
        write_reg(slpg_pkg::CFG_SLOW_HALF, slow);
        write_reg(slpg_pkg::CFG_FAST_HALF, fast);
        write_reg(slpg_pkg::CFG_RAINBOW_STEP, step);
        write_reg(slpg_pkg::CFG_STROBE_ON, on_time);
        write_reg(slpg_pkg::CFG_STROBE_OFF, off_time);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_period();
        if ($urandom_range(0, 4) == 0)
        begin
            return 16'($urandom_range(7, 40));
        end
        return 16'($urandom_range(1, 6));
    endfunction

    initial
    begin
        int m;
        int n;
        int p;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: every mode once, the same mode twice, a tick after each odd mode.
        send_request(slpg_pkg::REQ_SET_MODE, slpg_pkg::MODE_OFF);
        for (m = 1; m < 16; m++)
        begin
            send_request(slpg_pkg::REQ_SET_MODE, 4'(m));
            if (m % 2 == 1)
            begin
                send_request(slpg_pkg::REQ_TICK, 4'(~m));
            end
        end
        send_request(slpg_pkg::REQ_SET_MODE, slpg_pkg::MODE_STEADY_A);
        send_request(slpg_pkg::REQ_SET_MODE, slpg_pkg::MODE_STEADY_A);
        send_request(slpg_pkg::REQ_SET_MODE, slpg_pkg::MODE_OFF);
        wait_all_colors();

        // Zero periods advance on every tick; sweep the whole wheel and wrap it.
        program_regs(16'h0000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_request(slpg_pkg::REQ_SET_MODE, slpg_pkg::MODE_RAINBOW);
        for (n = 0; n < 300; n++)
        begin
            send_request(slpg_pkg::REQ_TICK, 4'($urandom));
        end
        for (n = 0; n < 100; n++)
        begin
            send_random_request();
        end
        wait_all_colors();

        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (n = 0; n < 40; n++)
        begin
            send_random_request();
        end
        wait_all_colors();

        tx_gaps = 1'b0;
        program_regs(16'($urandom), 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        for (n = 0; n < 150; n++)
        begin
            send_random_request();
        end
        wait_all_colors();

        for (p = 4; p < 10; p++)
        begin
            tx_gaps   = (p != 6 && p != 8);
            rx_stalls = (p != 4 && p != 7);
            program_regs(16'($urandom), pick_period(), pick_period(), pick_period(),
                         pick_period(), pick_period());
            for (n = 0; n < 150; n++)
            begin
                if (p == 6 && n == 20)
                begin
                    long_hold_req = 1'b1;
                end
                if (p == 5 && n == 75)
                begin
                    wait_all_colors();
                end
                send_random_request();
            end
            wait_all_colors();
        end

        if (errors == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
